/* rtl/core/rmq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// shared widths, pipeline payload and the per-stage function for the
// rotation matrix to quaternion pipeline
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int F     = 14;                       // fraction bits
  localparam int ONE   = 1 << F;
  localparam int ARGSW = ((F + 3) > 19) ? (F + 3) : 19;  // signed root argument
  localparam int AW    = ARGSW - 1;                // clamped argument
  localparam int SQW   = AW + F;                   // root input width
  localparam int RW    = (SQW + 1) / 2;            // root width
  localparam int SW    = 2 * RW;
  localparam int MGW   = 17;                       // magnitude of a difference
  localparam int NW    = MGW + F + 1;              // dividend width
  localparam int QW    = F + 1;                    // quotient bits below overflow
  localparam int XW    = NW + RW + 2;              // compare width
  localparam int K     = 4;                        // iterations per stage
  localparam int SQ    = (RW + K - 1) / K;
  localparam int DV    = (QW + K - 1) / K;
  localparam int NS    = SQ + DV + 3;
  localparam int QMAX  = (ONE > 32767) ? 32767 : ONE;

  localparam logic [1:0] CX = 2'd0;
  localparam logic [1:0] CY = 2'd1;
  localparam logic [1:0] CZ = 2'd2;
  localparam logic [1:0] CW = 2'd3;

  typedef struct packed {
    logic [SW-1:0]            srem;
    logic [SW-1:0]            sres;
    logic [3:0][MGW-1:0]      mag;
    logic [3:0]               neg;
    logic [1:0]               msel;
    logic [3:0][NW-1:0]       drem;
    logic [3:0][QW-1:0]       quo;
    logic [3:0]               ovf;
    logic                     zr;
    logic [3:0][15:0]         qo;
  } pipe_t;

  function automatic pipe_t stage_fn(input pipe_t p, input int s);
    pipe_t          o;
    logic [SW:0]    bit_v;
    logic [SW:0]    trial;
    logic [RW-1:0]  root;
    logic [XW-1:0]  den;
    logic [XW-1:0]  num;
    logic [XW-1:0]  dsh;
    logic [XW-1:0]  v;
    logic           ng;
    int             t;
    o    = p;
    root = p.sres[RW-1:0];
    den  = XW'(root) << 1;
    if (s >= 1 && s <= SQ) begin
      for (int u = 0; u < K; u++) begin
        t = (s - 1) * K + u;
        if (t < RW) begin
          bit_v = (SW+1)'(1) << (2 * (RW - 1 - t));
          trial = {1'b0, o.sres} + bit_v;
          if ({1'b0, o.srem} >= trial) begin
            o.srem = o.srem - trial[SW-1:0];
            o.sres = (o.sres >> 1) + bit_v[SW-1:0];
          end else begin
            o.sres = o.sres >> 1;
          end
        end
      end
    end else if (s == SQ + 1) begin
      o.zr = (root == '0);
      for (int c = 0; c < 4; c++) begin
        num       = (XW'(p.mag[c]) << F) + XW'(root);
        o.drem[c] = num[NW-1:0];
        o.quo[c]  = '0;
        o.ovf[c]  = (num >= (den << QW));
      end
    end else if (s <= SQ + 1 + DV) begin
      for (int u = 0; u < K; u++) begin
        t = (s - SQ - 2) * K + u;
        if (t < QW) begin
          for (int c = 0; c < 4; c++) begin
            dsh = den << (QW - 1 - t);
            if (XW'(o.drem[c]) >= dsh) begin
              num       = XW'(o.drem[c]) - dsh;
              o.drem[c] = num[NW-1:0];
              o.quo[c][QW-1-t] = 1'b1;
            end
          end
        end
      end
    end else begin
      for (int c = 0; c < 4; c++) begin
        ng = p.neg[c];
        if (2'(c) == p.msel) begin
          v  = (XW'(root) + XW'(1)) >> 1;
          ng = 1'b0;
        end else if (p.zr) begin
          v = '0;
        end else if (p.ovf[c]) begin
          v = XW'(ONE) + XW'(1);
        end else begin
          v = XW'(p.quo[c]);
        end
        if (v > XW'(ONE)) v = XW'(ONE);
        if (ng) begin
          if (v > XW'(32768)) v = XW'(32768);
          v = XW'(0) - v;
        end else if (v > XW'(32767)) begin
          v = XW'(32767);
        end
        o.qo[c] = v[15:0];
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/rmq_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_in_if
// matrix request channel: valid, ready and nine signed elements
// ----------------------------------------------------------------------------
interface rmq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
               output ready);
endinterface
`default_nettype wire

/* rtl/core/rmq_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_out_if
// quaternion result channel: valid, ready and four signed components
// ----------------------------------------------------------------------------
interface rmq_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
  modport source(output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink(input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface
`default_nettype wire

/* rtl/core/rotation_matrix_to_quaternion.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// rotation matrix (Q1.14) to quaternion by the largest-term branch method
// ----------------------------------------------------------------------------
// channel   dir  handshake        payload
// in_ch     in   valid / ready    m00 .. m22, signed 16 bit
// out_ch    out  valid / ready    quat_x, quat_y, quat_z, quat_w, signed 16 bit
//
// one request per cycle while out_ch is ready or a stage is empty; stages
// are 1 select, 4 root, 1 setup, 4 quotient, 1 format, set by the root and
// quotient iterations at 4 bits per stage. reset clears the stage valid bits
// only. a stall on out_ch holds the run of full stages next to the output;
// stages behind an empty stage still advance, so in_ch keeps taking requests until the whole pipe is occupied.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  wire logic clk,
  input  wire logic rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);
  rmq_pkg::pipe_t front_p;
  rmq_pkg::pipe_t last_p;

  rmq_front u_front (
    .m00(in_ch.m00), .m01(in_ch.m01), .m02(in_ch.m02),
    .m10(in_ch.m10), .m11(in_ch.m11), .m12(in_ch.m12),
    .m20(in_ch.m20), .m21(in_ch.m21), .m22(in_ch.m22),
    .p(front_p)
  );

  rmq_pipe u_pipe (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_p(front_p),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_p(last_p)
  );

  assign out_ch.quat_x = last_p.qo[0];
  assign out_ch.quat_y = last_p.qo[1];
  assign out_ch.quat_z = last_p.qo[2];
  assign out_ch.quat_w = last_p.qo[3];

  // back-pressure only comes from a full pipe behind a stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without output back-pressure");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($signed(out_ch.quat_x) <= rmq_pkg::QMAX
      && $signed(out_ch.quat_y) <= rmq_pkg::QMAX
      && $signed(out_ch.quat_z) <= rmq_pkg::QMAX
      && $signed(out_ch.quat_w) <= rmq_pkg::QMAX))
    else $error("quaternion component above saturation limit");
endmodule
`default_nettype wire

/* rtl/core/rmq_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_front
// branch select, root argument and signed differences per component
// ----------------------------------------------------------------------------
module rmq_front (
  input  wire logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
  output rmq_pkg::pipe_t          p
);
  localparam int AS = rmq_pkg::ARGSW;
  localparam int DW = rmq_pkg::MGW;

  logic signed [AS-1:0] e00, e11, e22, one_s, tr, arg;
  logic signed [DW-1:0] d [4];
  logic [1:0]           sel;

  always_comb begin
    e00   = AS'(m00);
    e11   = AS'(m11);
    e22   = AS'(m22);
    one_s = AS'(rmq_pkg::ONE);
    tr    = e00 + e11 + e22;
    sel   = rmq_pkg::CW;
    arg   = tr + one_s;
    d[0]  = DW'(m21) - DW'(m12);
    d[1]  = DW'(m02) - DW'(m20);
    d[2]  = DW'(m10) - DW'(m01);
    d[3]  = '0;
    if (tr <= 0) begin
      sel = rmq_pkg::CX;
      if (e11 > e00) sel = rmq_pkg::CY;
      if (e22 > ((sel == rmq_pkg::CY) ? e11 : e00)) sel = rmq_pkg::CZ;
      case (sel)
        rmq_pkg::CX: begin
          arg  = e00 - e11 - e22 + one_s;
          d[3] = DW'(m21) - DW'(m12);
          d[1] = DW'(m10) + DW'(m01);
          d[2] = DW'(m20) + DW'(m02);
          d[0] = '0;
        end
        rmq_pkg::CY: begin
          arg  = e11 - e22 - e00 + one_s;
          d[3] = DW'(m02) - DW'(m20);
          d[2] = DW'(m21) + DW'(m12);
          d[0] = DW'(m01) + DW'(m10);
          d[1] = '0;
        end
        default: begin
          arg  = e22 - e00 - e11 + one_s;
          d[3] = DW'(m10) - DW'(m01);
          d[0] = DW'(m02) + DW'(m20);
          d[1] = DW'(m12) + DW'(m21);
          d[2] = '0;
        end
      endcase
    end
    p      = '0;
    p.msel = sel;
    // negative argument clamps to zero
    if (arg > 0) p.srem = rmq_pkg::SW'(arg[rmq_pkg::AW-1:0]) << rmq_pkg::F;
    for (int c = 0; c < 4; c++) begin
      p.neg[c] = d[c][DW-1];
      p.mag[c] = d[c][DW-1] ? DW'(-d[c]) : DW'(d[c]);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/rmq_pipe.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pipe
// stage registers: root iterations, dividend setup, quotient iterations
// and output formatting, each stage stalls on its own
// ----------------------------------------------------------------------------
module rmq_pipe (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire rmq_pkg::pipe_t in_p,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rmq_pkg::pipe_t      out_p
);
  localparam int NS = rmq_pkg::NS;

  logic [NS-1:0]  v_r;
  rmq_pkg::pipe_t p_r [NS];
  logic [NS:0]    take;

  assign take[NS] = out_ready;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    assign take[s] = !v_r[s] || take[s+1];
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (take[s]) begin
          v_r[s] <= in_valid;
        end
        if (take[s]) p_r[s] <= in_p;
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (take[s]) begin
          v_r[s] <= v_r[s-1];
        end
        if (take[s]) p_r[s] <= rmq_pkg::stage_fn(p_r[s-1], s);
      end
    end
  end

  assign in_ready  = take[0];
  assign out_valid = v_r[NS-1];
  assign out_p     = p_r[NS-1];
endmodule
`default_nettype wire

/* test/tb_rotation_matrix_to_quaternion.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// drives rotation matrices through the converter, predicts every quaternion
// with an integer model of the trace and largest-diagonal branches and
// checks each component in order, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;

  localparam int F   = rmq_pkg::F;
  localparam int ONE = rmq_pkg::ONE;

  typedef struct packed {
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  typedef struct packed {
    logic signed [15:0] x, y, z, w;
  } quat_t;

  localparam int ITEMS     = 550;
  localparam int WATCHDOG  = 5000;
  localparam int DRAIN     = 30;
  localparam int LONG_HOLD = 60;
  localparam int PAUSE_AT  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rmq_in_if  in_ch();
  rmq_out_if out_ch();

  rotation_matrix_to_quaternion uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  matrix_t pending_q[$];
  quat_t   expected_q[$];
  int      errors = 0;
  int      accepted = 0;
  int      checked = 0;
  int      idle_cycles = 0;
  bit      stim_done = 1'b0;
  bit      hold_rx = 1'b0;
  int      n_trace = 0;
  int      n_diag = 0;
  bit      in_took = 1'b0;
  bit      out_took = 1'b0;

  function automatic longint int_sqrt(longint a);
    longint res;
    longint b;
    res = 0;
    b = 64'sd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= res + b) begin
        a = a - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint root_from(longint arg);
    if (arg < 0) arg = 0;
    return int_sqrt(arg << F);
  endfunction

  // difference scaled by 1/(2*root), rounded half away from zero
  function automatic longint scaled_diff(longint d, longint root);
    longint mag;
    longint q;
    if (root == 0) return 0;
    mag = (d < 0 ? -d : d) << F;
    q = (mag + root) / (2 * root);
    return d < 0 ? -q : q;
  endfunction

  function automatic logic signed [15:0] clip(longint v);
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t mx);
    longint m[3][3];
    longint q[4];
    longint tr;
    longint r;
    int     i, j, k;
    quat_t  o;
    m[0][0] = mx.m00; m[0][1] = mx.m01; m[0][2] = mx.m02;
    m[1][0] = mx.m10; m[1][1] = mx.m11; m[1][2] = mx.m12;
    m[2][0] = mx.m20; m[2][1] = mx.m21; m[2][2] = mx.m22;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      r = root_from(tr + ONE);
      q[3] = (r + 1) >> 1;
      q[0] = scaled_diff(m[2][1] - m[1][2], r);
      q[1] = scaled_diff(m[0][2] - m[2][0], r);
      q[2] = scaled_diff(m[1][0] - m[0][1], r);
    end else begin
      // largest diagonal, ties keep the lower index
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      r = root_from(m[i][i] - (m[j][j] + m[k][k]) + ONE);
      q[i] = (r + 1) >> 1;
      q[3] = scaled_diff(m[k][j] - m[j][k], r);
      q[j] = scaled_diff(m[j][i] + m[i][j], r);
      q[k] = scaled_diff(m[k][i] + m[i][k], r);
    end
    o.x = clip(q[0]);
    o.y = clip(q[1]);
    o.z = clip(q[2]);
    o.w = clip(q[3]);
    return o;
  endfunction

  function automatic logic signed [15:0] rand_elem();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'($urandom);
    if (sel == 1) return ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // proper rotation about a principal axis
  function automatic matrix_t rand_rotation();
    matrix_t mx;
    int c, s, ax;
    c = $signed($urandom_range(0, 32768)) - 16384;
    s = int'(int_sqrt(longint'(ONE) * ONE - longint'(c) * c));
    if ($urandom_range(0, 1)) s = -s;
    ax = $urandom_range(0, 2);
    mx = '0;
    case (ax)
      0: begin
        mx.m00 = 16'(ONE); mx.m11 = 16'(c); mx.m12 = 16'(-s); mx.m21 = 16'(s);
        mx.m22 = 16'(c);
      end
      1: begin
        mx.m11 = 16'(ONE); mx.m00 = 16'(c); mx.m02 = 16'(s); mx.m20 = 16'(-s);
        mx.m22 = 16'(c);
      end
      default: begin
        mx.m22 = 16'(ONE); mx.m00 = 16'(c); mx.m01 = 16'(-s); mx.m10 = 16'(s);
        mx.m11 = 16'(c);
      end
    endcase
    return mx;
  endfunction

  function automatic matrix_t diag(int a, int b, int c);
    matrix_t mx;
    mx = '0;
    mx.m00 = 16'(a); mx.m11 = 16'(b); mx.m22 = 16'(c);
    return mx;
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t mx;
    mx.m00 = rand_elem(); mx.m01 = rand_elem(); mx.m02 = rand_elem();
    mx.m10 = rand_elem(); mx.m11 = rand_elem(); mx.m12 = rand_elem();
    mx.m20 = rand_elem(); mx.m21 = rand_elem(); mx.m22 = rand_elem();
    return mx;
  endfunction

  // prediction on the accepting edge, handshake flags for both sides
  always @(posedge clk) begin
    in_took  <= rst_n && in_ch.valid && in_ch.ready;
    out_took <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready)
      expected_q.push_back(matrix_to_quat({in_ch.m00, in_ch.m01, in_ch.m02,
        in_ch.m10, in_ch.m11, in_ch.m12, in_ch.m20, in_ch.m21, in_ch.m22}));
  end

  // driver
  int      tx_wait = 0;
  bit      pause_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
       in_ch.m20, in_ch.m21, in_ch.m22} <= '0;
    end else begin
      if (in_took) begin
        void'(pending_q.pop_front());
        accepted++;
        tx_wait = (accepted % 100 < 30) ? 0 : int'($urandom_range(0, 8));
      end
      // one pause mid-run until every result is back
      if (accepted == PAUSE_AT && !pause_done && expected_q.size() == 0)
        pause_done = 1'b1;
      if (in_ch.valid && !in_took) begin
        // request still waiting, hold it
      end else if (pending_q.size() > 0 && tx_wait == 0 &&
                   !(accepted == PAUSE_AT && !pause_done)) begin
        in_ch.valid <= 1'b1;
        {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
         in_ch.m20, in_ch.m21, in_ch.m22} <= pending_q[0];
      end else begin
        in_ch.valid <= 1'b0;
        if (tx_wait > 0) tx_wait--;
      end
    end
  end

  // receiver stall pattern
  int rx_wait = 0;

  always @(negedge clk) begin
    if (!rst_n || hold_rx) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_took)
        rx_wait = (checked % 120 < 25) ? 0 : int'($urandom_range(0, 8));
      if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long hold-off so the pipe fills and backs up the input
  int hold_count = 0;
  always @(posedge clk) begin
    if (accepted == 150 && hold_count == 0) begin
      hold_rx <= 1'b1;
      hold_count <= 1;
    end else if (hold_rx) begin
      if (hold_count == LONG_HOLD) hold_rx <= 1'b0;
      else hold_count <= hold_count + 1;
    end
  end

  // monitor
  quat_t got, want;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.quat_x, out_ch.quat_y, out_ch.quat_z, out_ch.quat_w};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected quaternion %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        if (got.x !== want.x) begin
          errors++;
          $display("%0t: quat_x expected %0d actual %0d", $time, want.x, got.x);
        end
        if (got.y !== want.y) begin
          errors++;
          $display("%0t: quat_y expected %0d actual %0d", $time, want.y, got.y);
        end
        if (got.z !== want.z) begin
          errors++;
          $display("%0t: quat_z expected %0d actual %0d", $time, want.z, got.z);
        end
        if (got.w !== want.w) begin
          errors++;
          $display("%0t: quat_w expected %0d actual %0d", $time, want.w, got.w);
        end
      end
      checked++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    matrix_t mx;
    int      tr;
    // identity, trace branch and each diagonal branch
    pending_q.push_back(diag(ONE, ONE, ONE));
    pending_q.push_back(diag(ONE, -ONE, -ONE));
    pending_q.push_back(diag(-ONE, ONE, -ONE));
    pending_q.push_back(diag(-ONE, -ONE, ONE));
    // ties on the diagonal, zero trace
    pending_q.push_back(diag(0, 0, 0));
    pending_q.push_back(diag(-ONE, -ONE, -ONE));
    pending_q.push_back(diag(-8192, -8192, 8192));
    // negative diagonal element on the trace branch
    pending_q.push_back(diag(-ONE, ONE, ONE));
    // extreme raw codes and saturation
    mx = {9{16'sh7fff}}; pending_q.push_back(mx);
    mx = {9{16'sh8000}}; pending_q.push_back(mx);
    mx = diag(1, 0, 0); mx.m21 = 16'sh7fff; mx.m12 = 16'sh8000;
    pending_q.push_back(mx);
    mx = diag(-ONE, -ONE, -ONE); mx.m01 = 16'sh7fff; mx.m10 = 16'sh7fff;
    mx.m20 = 16'sh8000; mx.m02 = 16'sh8000; pending_q.push_back(mx);
    mx = {16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa,
          16'sh5555, 16'shaaaa, 16'sh5555};
    pending_q.push_back(mx);
    mx = ~mx; pending_q.push_back(mx);
    for (int a = 0; a < 6; a++) pending_q.push_back(rand_rotation());
    for (int n = pending_q.size(); n < ITEMS; n++)
      pending_q.push_back($urandom_range(0, 9) < 6 ? rand_rotation() : rand_matrix());
    foreach (pending_q[n]) begin
      tr = pending_q[n].m00 + pending_q[n].m11 + pending_q[n].m22;
      if (tr > 0) n_trace++;
      else n_diag++;
    end
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    wait (pending_q.size() == 0 && !in_ch.valid);
    wait (expected_q.size() == 0);
    repeat (DRAIN) @(posedge clk);
    $display("converted %0d matrices, %0d on the trace branch, %0d on the diagonal",
             checked, n_trace, n_diag);
    $display("with random stalls, one long output hold-off and one input drain pause");
    if (errors == 0 && expected_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
